// ===== design/phc_pkg.sv =====
// Package for the half-plane polygon clipper: register indexes, fixed widths
// and shared types. Depends on nothing; phc_mul, phc_div and the core import it.
package phc_pkg;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned NRM_BITS      = 16;
  localparam int unsigned DOT_BITS      = 32;
  localparam int unsigned T_BITS        = 16;
  localparam int unsigned T_CNT_BITS    = $clog2(T_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_PLANE_OFFSET = 2'd2
  } cfg_reg_e;

  typedef logic signed [DOT_BITS-1:0] dot_t;
  typedef logic [DOT_BITS-1:0]        mag_t;
  typedef logic [T_BITS-1:0]          frac_t;

endpackage

// ===== design/phc_in_if.sv =====
// Vertex input channel of the half-plane clipper: valid/ready plus one vertex.
// Depends on nothing; the width follows the COORD_BITS parameter.
interface phc_in_if #(
  parameter int unsigned COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// ===== design/phc_out_if.sv =====
// Result channel of the half-plane clipper: valid/ready plus one clipped vertex.
// Depends on nothing; the width follows the COORD_BITS parameter.
interface phc_out_if #(
  parameter int unsigned COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_valid;
  logic                         out_last;

  modport source (output valid, out_x, out_y, out_valid, out_last, input ready);
  modport sink   (input valid, out_x, out_y, out_valid, out_last, output ready);
endinterface

// ===== design/phc_mul.sv =====
// Shared signed multiplier of the clipper with a registered product.
// Depends on phc_pkg for the common import only.
module phc_mul import phc_pkg::*; #(
  parameter int unsigned AW = 17,
  parameter int unsigned BW = 17
) (
  input  logic                    clk_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] p_q;
  logic signed [AW+BW-1:0] p_d;

  assign p_d = a_i * b_i;
  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

endmodule

// ===== design/phc_div.sv =====
// Restoring divider giving the crossing fraction num * 2^16 / den, one bit a
// cycle, saturated to all ones when num is not below den. Depends on phc_pkg.
module phc_div import phc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  mag_t  num_i,
  input  mag_t  den_i,
  output logic  done_o,
  output frac_t quot_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [T_CNT_BITS-1:0] cnt_q, cnt_d;
  mag_t                  rem_q, rem_d;
  mag_t                  den_q, den_d;
  frac_t                 quot_q, quot_d;
  logic [DOT_BITS:0]     rem2;
  logic [DOT_BITS:0]     diff;
  logic                  ge;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = rem2 >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      if (num_i >= den_i) begin
        quot_d = '1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = num_i;
        den_d  = den_i;
        cnt_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[DOT_BITS-1:0] : rem2[DOT_BITS-1:0];
      quot_d = {quot_q[T_BITS-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == T_CNT_BITS'(T_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/polygon_half_plane_clipper_core.sv =====
// Half-plane polygon clipper (one clipping plane, Sutherland-Hodgman order).
// Depends on phc_pkg, phc_in_if, phc_out_if, phc_mul and phc_div.
//
// Usage: vertices arrive one beat at a time on in_i, the final vertex of a
// polygon flagged by last_vertex. Clipped vertices leave on out_o; the final
// beat of a polygon carries out_last, and a polygon that clips away entirely
// gives a single beat with out_valid low and out_last high. The plane is set
// through cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle.
// Throughput: one vertex at a time. Each dot product runs on the shared
// multiplier, and each crossing waits on the 16-step divider that forms the
// crossing fraction (it answers without stepping when the fraction
// saturates), so a closing vertex can wait on the divider twice.
// in_i.ready is high only between vertices. Results pass through a one-entry
// pending buffer and an output register. When the receiver stalls, the output
// register holds its beat, and the block waits only where it must move a
// pending result or a final beat into it. Reset restores the default plane,
// forgets any partly received polygon and empties the output register.
module polygon_half_plane_clipper_core import phc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  phc_in_if.sink                   in_i,
  phc_out_if.source                out_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = CB + 1;
  localparam int unsigned BW = T_BITS + 1;
  localparam int unsigned MW = AW + BW;
  localparam int unsigned SW = (MW + 1 > DOT_BITS + 1) ? MW + 1 : DOT_BITS + 1;
  localparam logic signed [SW-1:0] DOT_MAX =
    {{(SW-DOT_BITS+1){1'b0}}, {(DOT_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] DOT_MIN =
    {{(SW-DOT_BITS+1){1'b1}}, {(DOT_BITS-1){1'b0}}};

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_DX     = 13'b0000000000010,
    ST_DY     = 13'b0000000000100,
    ST_DSUM   = 13'b0000000001000,
    ST_EDGE   = 13'b0000000010000,
    ST_DIV    = 13'b0000000100000,
    ST_CX     = 13'b0000001000000,
    ST_CY     = 13'b0000010000000,
    ST_CSUM   = 13'b0000100000000,
    ST_EMIT_C = 13'b0001000000000,
    ST_EMIT_B = 13'b0010000000000,
    ST_FLUSH  = 13'b0100000000000,
    ST_SPARE  = 13'b1000000000000
  } state_e;

  typedef logic signed [CB-1:0] coord_t;

  state_e state_q, state_d;

  logic signed [NRM_BITS-1:0] nx_q, nx_d;
  logic signed [NRM_BITS-1:0] ny_q, ny_d;
  dot_t                       off_q, off_d;

  logic have_first_q, have_first_d;
  logic last_q, last_d;
  logic hf_q, hf_d;
  logic pt_q, pt_d;
  logic edge_q, edge_d;
  logic pend_v_q, pend_v_d;
  logic out_v_q, out_v_d;

  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t first_x_q, first_x_d, first_y_q, first_y_d;
  coord_t prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  coord_t cross_x_q, cross_x_d, cross_y_q, cross_y_d;
  coord_t pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  coord_t out_x_q, out_x_d, out_y_q, out_y_d;
  logic   out_ok_q, out_ok_d, out_last_q, out_last_d;
  dot_t   prev_dot_q, prev_dot_d, cur_dot_q, cur_dot_d, first_dot_q, first_dot_d;
  frac_t  t_q, t_d;
  logic signed [MW-1:0] acc_q, acc_d;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [MW-1:0] prod;
  logic signed [SW-1:0] dsum;
  dot_t                 dot_sat;

  coord_t px, py, ax, ay, bx, by;
  dot_t   adot, bdot;
  logic   a_in, b_in, edge_more, out_free;
  logic signed [DOT_BITS:0] num_s, den_s;
  logic [DOT_BITS:0]        num_abs, den_abs;
  logic                     div_start, div_done;
  frac_t                    div_quot;

  phc_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  phc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_abs[DOT_BITS-1:0]),
    .den_i   (den_abs[DOT_BITS-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign px = pt_q ? first_x_q : cur_x_q;
  assign py = pt_q ? first_y_q : cur_y_q;

  assign ax   = edge_q ? cur_x_q : prev_x_q;
  assign ay   = edge_q ? cur_y_q : prev_y_q;
  assign adot = edge_q ? cur_dot_q : prev_dot_q;
  assign bx   = edge_q ? first_x_q : cur_x_q;
  assign by   = edge_q ? first_y_q : cur_y_q;
  assign bdot = edge_q ? first_dot_q : cur_dot_q;

  assign a_in  = adot <= off_q;
  assign b_in  = bdot <= off_q;
  assign num_s = {off_q[DOT_BITS-1], off_q} - {adot[DOT_BITS-1], adot};
  assign den_s = {bdot[DOT_BITS-1], bdot} - {adot[DOT_BITS-1], adot};
  assign num_abs = num_s[DOT_BITS] ? -num_s : num_s;
  assign den_abs = den_s[DOT_BITS] ? -den_s : den_s;

  assign dsum = {{(SW-MW){acc_q[MW-1]}}, acc_q} + {{(SW-MW){prod[MW-1]}}, prod};
  assign dot_sat = (dsum > DOT_MAX) ? DOT_MAX[DOT_BITS-1:0] :
                   (dsum < DOT_MIN) ? DOT_MIN[DOT_BITS-1:0] : dsum[DOT_BITS-1:0];

  assign edge_more = !edge_q && last_q;
  assign out_free  = !out_v_q || out_o.ready;

  always_comb begin
    nx_d = nx_q;
    ny_d = ny_q;
    off_d = off_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NORMAL_X:     nx_d  = cfg_data_i[NRM_BITS-1:0];
        REG_NORMAL_Y:     ny_d  = cfg_data_i[NRM_BITS-1:0];
        REG_PLANE_OFFSET: off_d = cfg_data_i[DOT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    have_first_d = have_first_q;
    last_d       = last_q;
    hf_d         = hf_q;
    pt_d         = pt_q;
    edge_d       = edge_q;
    pend_v_d     = pend_v_q;
    out_v_d      = out_v_q && !out_o.ready;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    cross_x_d    = cross_x_q;
    cross_y_d    = cross_y_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_ok_d     = out_ok_q;
    out_last_d   = out_last_q;
    prev_dot_d   = prev_dot_q;
    cur_dot_d    = cur_dot_q;
    first_dot_d  = first_dot_q;
    t_d          = t_q;
    acc_d        = acc_q;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cur_x_d = in_i.vertex_x;
          cur_y_d = in_i.vertex_y;
          last_d  = in_i.last_vertex;
          hf_d    = have_first_q;
          if (!have_first_q) begin
            first_x_d = in_i.vertex_x;
            first_y_d = in_i.vertex_y;
          end
          pt_d    = 1'b0;
          state_d = ST_DX;
        end
      end
      ST_DX: begin
        mul_a   = {px[CB-1], px};
        mul_b   = {nx_q[NRM_BITS-1], nx_q};
        state_d = ST_DY;
      end
      ST_DY: begin
        mul_a   = {py[CB-1], py};
        mul_b   = {ny_q[NRM_BITS-1], ny_q};
        acc_d   = prod;
        state_d = ST_DSUM;
      end
      ST_DSUM: begin
        if (!pt_q) begin
          cur_dot_d = dot_sat;
          if (hf_q) begin
            edge_d  = 1'b0;
            state_d = ST_EDGE;
          end else if (last_q) begin
            pt_d    = 1'b1;
            state_d = ST_DX;
          end else begin
            state_d = ST_FLUSH;
          end
        end else begin
          first_dot_d = dot_sat;
          edge_d      = 1'b1;
          state_d     = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (a_in != b_in) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else if (b_in) begin
          state_d = ST_EMIT_B;
        end else if (edge_more) begin
          pt_d    = 1'b1;
          state_d = ST_DX;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          t_d     = div_quot;
          state_d = ST_CX;
        end
      end
      ST_CX: begin
        mul_a   = {bx[CB-1], bx} - {ax[CB-1], ax};
        mul_b   = {1'b0, t_q};
        state_d = ST_CY;
      end
      ST_CY: begin
        mul_a   = {by[CB-1], by} - {ay[CB-1], ay};
        mul_b   = {1'b0, t_q};
        acc_d   = prod;
        state_d = ST_CSUM;
      end
      ST_CSUM: begin
        cross_x_d = ax + acc_q[T_BITS +: CB];
        cross_y_d = ay + prod[T_BITS +: CB];
        state_d   = ST_EMIT_C;
      end
      ST_EMIT_C: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_x_d    = pend_x_q;
            out_y_d    = pend_y_q;
            out_ok_d   = 1'b1;
            out_last_d = 1'b0;
          end
          pend_x_d = cross_x_q;
          pend_y_d = cross_y_q;
          pend_v_d = 1'b1;
          if (b_in) begin
            state_d = ST_EMIT_B;
          end else if (edge_more) begin
            pt_d    = 1'b1;
            state_d = ST_DX;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_EMIT_B: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_x_d    = pend_x_q;
            out_y_d    = pend_y_q;
            out_ok_d   = 1'b1;
            out_last_d = 1'b0;
          end
          pend_x_d = bx;
          pend_y_d = by;
          pend_v_d = 1'b1;
          if (edge_more) begin
            pt_d    = 1'b1;
            state_d = ST_DX;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!(pend_v_q || last_q) || out_free) begin
          if (pend_v_q || last_q) begin
            out_v_d    = 1'b1;
            out_x_d    = pend_v_q ? pend_x_q : '0;
            out_y_d    = pend_v_q ? pend_y_q : '0;
            out_ok_d   = pend_v_q;
            out_last_d = last_q;
          end
          pend_v_d     = 1'b0;
          prev_x_d     = cur_x_q;
          prev_y_d     = cur_y_q;
          prev_dot_d   = cur_dot_q;
          have_first_d = !last_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      nx_q         <= NRM_BITS'(16384);
      ny_q         <= '0;
      off_q        <= '0;
      have_first_q <= 1'b0;
      last_q       <= 1'b0;
      hf_q         <= 1'b0;
      pt_q         <= 1'b0;
      edge_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      nx_q         <= nx_d;
      ny_q         <= ny_d;
      off_q        <= off_d;
      have_first_q <= have_first_d;
      last_q       <= last_d;
      hf_q         <= hf_d;
      pt_q         <= pt_d;
      edge_q       <= edge_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    first_x_q   <= first_x_d;
    first_y_q   <= first_y_d;
    prev_x_q    <= prev_x_d;
    prev_y_q    <= prev_y_d;
    cross_x_q   <= cross_x_d;
    cross_y_q   <= cross_y_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_ok_q    <= out_ok_d;
    out_last_q  <= out_last_d;
    prev_dot_q  <= prev_dot_d;
    cur_dot_q   <= cur_dot_d;
    first_dot_q <= first_dot_d;
    t_q         <= t_d;
    acc_q       <= acc_d;
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_v_q;
  assign out_o.out_x     = out_x_q;
  assign out_o.out_y     = out_y_q;
  assign out_o.out_valid = out_ok_q;
  assign out_o.out_last  = out_last_q;

  a_accept_starts_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_DX)
    else $error("Accepted vertex did not start its dot product.");

  a_idle_pend_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("Pending result left behind at the end of a vertex.");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("Divider finished outside the division wait.");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_valid |-> out_o.out_last)
    else $error("Empty-polygon beat without the last flag.");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("Sequencer state is not one-hot.");

endmodule

// ===== verif/tb_polygon_half_plane_clipper_core.sv =====
// Testbench for polygon_half_plane_clipper_core: streams polygons under several planes and
// checks every clipped beat against a built-in Sutherland-Hodgman predictor.
// Depends on phc_pkg, phc_in_if, phc_out_if and the clipper core.
`timescale 1ns / 100ps

module tb_polygon_half_plane_clipper_core;
  import phc_pkg::*;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam longint      DOT_MAX       = 64'sd2147483647;
  localparam longint      DOT_MIN       = -64'sd2147483648;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   vld;
    logic   lst;
  } clip_pt_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  phc_in_if  #(.COORD_BITS(COORD_BITS)) in_if  ();
  phc_out_if #(.COORD_BITS(COORD_BITS)) out_if ();

  polygon_half_plane_clipper_core #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Plane and polygon state of the predictor.
  longint   pl_nx;
  longint   pl_ny;
  longint   pl_d;
  bit       poly_open;
  longint   first_x;
  longint   first_y;
  longint   prev_x;
  longint   prev_y;
  longint   prev_dot;

  clip_pt_t    step_pts[$];
  clip_pt_t    expected_pts[$];
  int unsigned mismatch_cnt;
  int unsigned vertex_cnt;
  int unsigned idle_cycles;
  int unsigned hold_len;
  bit          gaps_on;
  bit          stalls_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint plane_dot(longint x, longint y);
    longint s;
    s = pl_nx * x + pl_ny * y;
    if (s > DOT_MAX) s = DOT_MAX;
    if (s < DOT_MIN) s = DOT_MIN;
    return s;
  endfunction

  function automatic void add_pt(longint x, longint y, logic vld);
    clip_pt_t p;
    p.x   = x[COORD_BITS-1:0];
    p.y   = y[COORD_BITS-1:0];
    p.vld = vld;
    p.lst = 1'b0;
    step_pts = {step_pts, p};
  endfunction

  function automatic void clip_segment(longint ax, longint ay, longint adot,
                                       longint bx, longint by, longint bdot);
    bit              a_in;
    bit              b_in;
    longint          num;
    longint          den;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned tq;
    longint          ts;
    a_in = adot <= pl_d;
    b_in = bdot <= pl_d;
    if (a_in != b_in) begin
      num = pl_d - adot;
      den = bdot - adot;
      un  = (num < 0) ? -num : num;
      ud  = (den < 0) ? -den : den;
      tq  = (un << 16) / ud;
      if (tq > 65535) tq = 65535;
      ts  = tq;
      add_pt(ax + (((bx - ax) * ts) >>> 16), ay + (((by - ay) * ts) >>> 16), 1'b1);
    end
    if (b_in) add_pt(bx, by, 1'b1);
  endfunction

  function automatic void predict_clip(coord_t vx, coord_t vy, logic lst);
    longint   x;
    longint   y;
    longint   d;
    x = vx;
    y = vy;
    d = plane_dot(x, y);
    step_pts.delete();
    if (!poly_open) begin
      poly_open = 1'b1;
      first_x   = x;
      first_y   = y;
    end else begin
      clip_segment(prev_x, prev_y, prev_dot, x, y, d);
    end
    prev_x   = x;
    prev_y   = y;
    prev_dot = d;
    if (lst) begin
      clip_segment(x, y, d, first_x, first_y, plane_dot(first_x, first_y));
      if (step_pts.size() == 0) add_pt(0, 0, 1'b0);
      step_pts[step_pts.size() - 1].lst = 1'b1;
      poly_open = 1'b0;
    end
    expected_pts = {expected_pts, step_pts};
  endfunction

  task automatic send_vertex(input coord_t x, input coord_t y, input logic lst);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.vertex_x    <= x;
    in_if.vertex_y    <= y;
    in_if.last_vertex <= lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_clip(x, y, lst);
    vertex_cnt++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_plane(input coord_t nx, input coord_t ny, input logic signed [31:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_NORMAL_X;
    cfg_data <= {{(CFG_DATA_BITS-16){nx[15]}}, nx};
    @(posedge clk);
    cfg_idx  <= REG_NORMAL_Y;
    cfg_data <= {{(CFG_DATA_BITS-16){ny[15]}}, ny};
    @(posedge clk);
    cfg_idx  <= REG_PLANE_OFFSET;
    cfg_data <= d;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pl_nx = nx;
    pl_ny = ny;
    pl_d  = d;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic coord_t rand_normal();
    if ($urandom_range(0, 4) == 0) return coord_t'($urandom_range(0, 65535));
    return coord_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [31:0] rand_offset();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh8000_0000;
      default: return int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    endcase
  endfunction

  task automatic send_random_polygon();
    int unsigned n;
    case ($urandom_range(0, 9))
      0:       n = 1;
      1:       n = 2;
      default: n = $urandom_range(3, 8);
    endcase
    for (int unsigned i = 0; i < n; i++) send_vertex(rand_coord(), rand_coord(), i == n - 1);
  endtask

  task automatic test_default_plane();
    send_vertex(-16'sd8192, -16'sd8192, 1'b0);
    send_vertex(16'sd8192, -16'sd8192, 1'b0);
    send_vertex(16'sd8192, 16'sd8192, 1'b0);
    send_vertex(16'sd0, 16'sd8192, 1'b1);
    send_vertex(16'sd100, 16'sd0, 1'b0);
    send_vertex(16'sd200, 16'sd300, 1'b0);
    send_vertex(16'sd16384, -16'sd5, 1'b1);
    send_vertex(-16'sd1, 16'sd5, 1'b1);
    send_vertex(16'sd1, 16'sd5, 1'b1);
    send_vertex(16'sh8000, 16'sh7fff, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
  endtask

  task automatic test_plane_extremes();
    settle();
    set_plane(16'sh8000, 16'sh8000, 32'sh7fff_ffff);
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sd0, 16'sh8000, 1'b1);
    settle();
    set_plane(16'sd16384, -16'sd16384, 32'sh8000_0000);
    send_vertex(16'sh8000, 16'sh7fff, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b1);
  endtask

  task automatic test_config_mid_polygon();
    settle();
    set_plane(16'sd16384, 16'sd0, 32'sd0);
    send_vertex(-16'sd4096, 16'sd0, 1'b0);
    send_vertex(16'sd4096, 16'sd0, 1'b0);
    settle();
    set_plane(16'sd0, 16'sd16384, 32'sh0200_0000);
    send_vertex(16'sd0, 16'sd8192, 1'b1);
  endtask

  task automatic test_random_polygons(input int unsigned count);
    int unsigned target;
    target = vertex_cnt + count;
    while (vertex_cnt < target) begin
      if ($urandom_range(0, 5) == 0) begin
        settle();
        set_plane(rand_normal(), rand_normal(), rand_offset());
      end
      send_random_polygon();
    end
  endtask

  task automatic test_output_backpressure();
    settle();
    set_plane(16'sd11585, -16'sd11585, 32'sd0);
    gaps_on  = 1'b0;
    hold_len = 300;
    for (int unsigned i = 0; i < 5; i++) begin
      for (int unsigned j = 0; j < 4; j++) send_vertex(rand_coord(), rand_coord(), j == 3);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_full_rate(input int unsigned count);
    int unsigned target;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    target    = vertex_cnt + count;
    while (vertex_cnt < target) send_random_polygon();
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_if.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Each accepted result beat is matched against the oldest expected point.
  always @(posedge clk) begin : check_beat
    clip_pt_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pts.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: x=%0d y=%0d valid=%0b last=%0b",
                   out_if.out_x, out_if.out_y, out_if.out_valid, out_if.out_last);
      end else begin
        want = expected_pts.pop_front();
        if (out_if.out_x !== want.x || out_if.out_y !== want.y ||
            out_if.out_valid !== want.vld || out_if.out_last !== want.lst) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: want x=%0d y=%0d v=%0b l=%0b, got x=%0d y=%0d v=%0b l=%0b",
                     want.x, want.y, want.vld, want.lst,
                     out_if.out_x, out_if.out_y, out_if.out_valid, out_if.out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_polygon_half_plane_clipper_core: errors");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_NORMAL_X;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.vertex_x    <= '0;
    in_if.vertex_y    <= '0;
    in_if.last_vertex <= 1'b0;
    pl_nx        = 16384;
    pl_ny        = 0;
    pl_d         = 0;
    poly_open    = 1'b0;
    first_x      = 0;
    first_y      = 0;
    prev_x       = 0;
    prev_y       = 0;
    prev_dot     = 0;
    mismatch_cnt = 0;
    vertex_cnt   = 0;
    idle_cycles  = 0;
    hold_len     = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_default_plane();
    test_plane_extremes();
    test_config_mid_polygon();
    test_random_polygons(230);
    test_output_backpressure();
    test_full_rate(40);

    settle();
    if (mismatch_cnt == 0 && expected_pts.size() == 0) begin
      $display("tb_polygon_half_plane_clipper_core: clean");
    end else begin
      $display("tb_polygon_half_plane_clipper_core: errors");
    end
    $finish;
  end

endmodule
